// ===== sv/ssdre_pkg.sv =====
// types and constants shared by the sorted-set delta run-length encoder
// no dependencies
`timescale 1ns / 1ps

package ssdre_pkg;

  localparam int VALUE_W = 16;

  localparam logic [VALUE_W-1:0] SMALL_LIMIT_RST = 16'd64;
  localparam logic [15:0]        REP_MAX         = 16'hFFFF;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               last;
  } in_item_t;

  typedef struct packed {
    logic [VALUE_W-1:0] code;
    logic               last_res;
  } out_item_t;

  // one queue entry carries every result of one input item
  typedef struct packed {
    logic      two;
    out_item_t first;
    out_item_t second;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== sv/ssdre_front.sv =====
// front end: accepts values, holds the encoder state and forms queue entries
// depends on ssdre_pkg
`timescale 1ns / 1ps

module ssdre_front import ssdre_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [15:0]  cfg_wdata,
  input  logic         in_valid,
  input  in_item_t     in_data,
  output logic         in_stall,
  input  q_status_t    q_stat,
  output logic         push,
  output q_entry_t     push_entry
);

  logic               set_open_r,   set_open_nxt;
  logic [VALUE_W-1:0] prev_value_r, prev_value_nxt;
  logic [VALUE_W-1:0] prev_code_r,  prev_code_nxt;
  logic [15:0]        rep_r,        rep_nxt;
  logic [VALUE_W-1:0] small_limit_r;

  logic               accept;
  logic               prev_small;
  logic [VALUE_W-1:0] gap;
  logic [15:0]        rep_sat;
  logic [15:0]        rep_sat_m1;
  logic [15:0]        rep_m1;

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !q_stat.full;

  assign prev_small = prev_code_r < small_limit_r;
  assign gap        = in_data.value - prev_value_r - VALUE_W'(1);
  assign rep_sat    = (rep_r == REP_MAX) ? rep_r : rep_r + 16'd1;
  assign rep_sat_m1 = rep_sat - 16'd1;
  assign rep_m1     = rep_r - 16'd1;

  always_comb begin
    set_open_nxt   = set_open_r;
    prev_value_nxt = prev_value_r;
    prev_code_nxt  = prev_code_r;
    rep_nxt        = rep_r;
    push           = 1'b0;
    push_entry     = '0;
    if (accept) begin
      if (!set_open_r) begin
        push                       = 1'b1;
        push_entry.first.code      = in_data.value;
        push_entry.first.last_res  = in_data.last;
        prev_value_nxt             = in_data.value;
        prev_code_nxt              = in_data.value;
        rep_nxt                    = '0;
        set_open_nxt               = !in_data.last;
      end else begin
        prev_value_nxt = in_data.value;
        if (prev_small && gap == prev_code_r) begin
          // gap repeats a small code: the run grows, and a last item flushes it
          rep_nxt = rep_sat;
          if (in_data.last) begin
            push                      = 1'b1;
            push_entry.first.last_res = 1'b1;
            if (rep_sat > 16'd1) begin
              push_entry.first.code = {rep_sat_m1[VALUE_W-2:0], 1'b1};
            end else begin
              push_entry.first.code = {prev_code_r[VALUE_W-2:0], 1'b0};
            end
            rep_nxt      = '0;
            set_open_nxt = 1'b0;
          end
        end else begin
          push = 1'b1;
          if (rep_r != 16'd0) begin
            push_entry.two             = 1'b1;
            push_entry.first.last_res  = 1'b0;
            push_entry.second.last_res = in_data.last;
            if (rep_r > 16'd1) begin
              push_entry.first.code  = {rep_m1[VALUE_W-2:0], 1'b1};
              push_entry.second.code = gap;
            end else begin
              // a run of one goes out as the shifted pair
              push_entry.first.code  = {prev_code_r[VALUE_W-2:0], 1'b0};
              push_entry.second.code = {gap[VALUE_W-2:0], 1'b0};
            end
            rep_nxt = '0;
          end else begin
            push_entry.first.code     = prev_small ? {gap[VALUE_W-2:0], 1'b0} : gap;
            push_entry.first.last_res = in_data.last;
          end
          prev_code_nxt = gap;
          if (in_data.last) begin
            set_open_nxt = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_open_r    <= 1'b0;
      prev_value_r  <= '0;
      prev_code_r   <= '0;
      rep_r         <= '0;
      small_limit_r <= SMALL_LIMIT_RST;
    end else begin
      set_open_r   <= set_open_nxt;
      prev_value_r <= prev_value_nxt;
      prev_code_r  <= prev_code_nxt;
      rep_r        <= rep_nxt;
      if (cfg_we) begin
        small_limit_r <= cfg_wdata;
      end
    end
  end

endmodule

// ===== sv/ssdre_fifo.sv =====
// short queue of result entries between front and back end
// depends on ssdre_pkg
`timescale 1ns / 1ps

module ssdre_fifo import ssdre_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  q_entry_t  push_entry,
  input  logic      pop,
  output q_entry_t  pop_entry,
  output q_status_t q_stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  q_entry_t         mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r,  count_nxt;

  assign q_stat.full  = (count_r == CNT_W'(DEPTH));
  assign q_stat.empty = (count_r == '0);
  assign pop_entry    = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    priority if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.full |-> !push)
    else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.empty |-> !pop)
    else $error("pop from empty queue");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");
`endif

endmodule

// ===== sv/ssdre_back.sv =====
// back end: takes queue entries and presents one or two result items each
// depends on ssdre_pkg
`timescale 1ns / 1ps

module ssdre_back import ssdre_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  q_status_t q_stat,
  input  q_entry_t  pop_entry,
  output logic      pop,
  output logic      out_valid,
  output out_item_t out_data,
  input  logic      out_stall
);

  q_entry_t cur_r,       cur_nxt;
  logic     cur_valid_r, cur_valid_nxt;
  logic     phase_r,     phase_nxt;
  logic     out_acc;
  logic     done;

  assign out_valid = cur_valid_r;
  assign out_data  = phase_r ? cur_r.second : cur_r.first;
  assign out_acc   = cur_valid_r && !out_stall;
  // entry finished once its final item is taken
  assign done      = out_acc && (phase_r || !cur_r.two);
  assign pop       = !q_stat.empty && (!cur_valid_r || done);

  always_comb begin
    cur_nxt       = cur_r;
    cur_valid_nxt = cur_valid_r;
    phase_nxt     = phase_r;
    if (out_acc && !phase_r && cur_r.two) begin
      phase_nxt = 1'b1;
    end else if (!cur_valid_r || done) begin
      cur_valid_nxt = pop;
      phase_nxt     = 1'b0;
      if (pop) begin
        cur_nxt = pop_entry;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      phase_r     <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      phase_r     <= phase_nxt;
    end
  end

`ifndef SYNTHESIS
  a_phase_two: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r |-> (cur_valid_r && cur_r.two))
    else $error("second item shown for single-item entry");
  a_stall_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_valid_r && out_stall) |=> (cur_valid_r && $stable(phase_r)))
    else $error("stalled result dropped");
  a_second_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && !phase_r && cur_r.two) |=> (phase_r && cur_valid_r))
    else $error("second item of entry skipped");
`endif

endmodule

// ===== sv/sorted_set_delta_rle_encoder_core.sv =====
// top level of the sorted-set delta run-length encoder
// depends on ssdre_pkg, ssdre_front, ssdre_fifo, ssdre_back
//
//  channel | ports                          | dir | moves
//  --------+--------------------------------+-----+------------------------------
//  input   | in_valid, in_stall, in_data    | in  | one set value and last flag
//  result  | out_valid, out_stall, out_data | out | one code and last_res flag
//  config  | cfg_we, cfg_wdata              | in  | small_limit register
//
// an item is taken every cycle while the queue has room; the front state
// update (subtracts and compares) closes in that cycle
// an item producing two codes holds the output register until both are taken,
// so the sustained rate is one cycle per code emitted while out_stall is low
// reset is synchronous and active low; small_limit returns to 64
// out_stall backs up into the QUEUE_DEPTH entry queue, then raises in_stall
`timescale 1ns / 1ps

module sorted_set_delta_rle_encoder_core import ssdre_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  input  in_item_t    in_data,
  output logic        in_stall,
  output logic        out_valid,
  output out_item_t   out_data,
  input  logic        out_stall
);

  q_status_t q_stat;
  logic      push;
  logic      pop;
  q_entry_t  push_entry;
  q_entry_t  pop_entry;

  ssdre_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_data    (in_data),
    .in_stall   (in_stall),
    .q_stat     (q_stat),
    .push       (push),
    .push_entry (push_entry)
  );

  ssdre_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .q_stat     (q_stat)
  );

  ssdre_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .pop_entry (pop_entry),
    .pop       (pop),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

endmodule
